### src/epsq_pkg.sv
// ----------------------------------------------------------------------------
// Entry phase sequencer package
// Shared phase, reason and action codes plus the configuration, observation
// and sequencer state types.
// ----------------------------------------------------------------------------
package epsq_pkg;

  localparam int unsigned VelW  = 23;
  localparam int unsigned ObsW  = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [2:0] {
    PH_PRE   = 3'd0,
    PH_TEMP  = 3'd1,
    PH_EQ    = 3'd2,
    PH_DRAG  = 3'd3,
    PH_TRANS = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    RS_NONE    = 3'd0,
    RS_START   = 3'd1,
    RS_RESTART = 3'd2,
    RS_CONTACT = 3'd3,
    RS_TEMP    = 3'd4,
    RS_ICPT    = 3'd5,
    RS_DRAG    = 3'd6,
    RS_HAND    = 3'd7
  } reason_e;

  typedef enum logic [1:0] {
    ACT_UPDATE  = 2'd0,
    ACT_INIT    = 2'd1,
    ACT_HANDOFF = 2'd2
  } action_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TEMP_EN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_VEL = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DRAG_EN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DRAG_VEL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR_EN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR_PH = 3'd5;

  typedef struct packed {
    logic            temp_gate_enable;
    logic [VelW-1:0] temp_end_velocity;
    logic            drag_gate_enable;
    logic [VelW-1:0] drag_end_velocity;
    logic            floor_enable;
    logic [2:0]      floor_phase;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [TimeW-1:0]        time_ms;
    logic signed [ObsW-1:0]  velocity;
    logic signed [ObsW-1:0]  dyn_pressure;
    logic                    restart;
    logic                    intercept_known;
    logic                    intercept_hit;
  } obs_t;

  typedef struct packed {
    logic             init;
    logic             done;
    phase_e           phase;
    reason_e          reason;
    phase_e           from;
    phase_e           to;
    logic [TimeW-1:0] time_ms;
    logic [VelW-1:0]  vel;
    logic             completed;
    logic [CntW-1:0]  count;
  } seq_state_t;

endpackage

### src/entry_phase_sequencer_core.sv
// ----------------------------------------------------------------------------
// Entry phase sequencer core
// Steps a vehicle through pre-entry, temperature control, equilibrium glide,
// constant drag and transition, and reports the record of the last move.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ---------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  observation, action in tuser
//  m_axis    out        m_axis_tvalid/m_axis_tready  ok flag and sequencer record
//  cfg       in         cfg_valid_i/cfg_ready_o      register index and value
//
// One observation per cycle while the output is not stalled: a transfer lands
// in the input register; once the result register is free, the step logic
// updates the sequencer state and loads the result register.
// The state register feeds back to the step logic, so each item sees the
// state left by the item before it. Reset clears state, configuration and
// valid flags. A stalled result holds both stages; the configuration port is
// always ready.
// ----------------------------------------------------------------------------
module entry_phase_sequencer_core import epsq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: time_ms[31:0], velocity[55:32], dyn_pressure[79:56], restart[80],
  //        intercept_known[81], intercept_hit[82], zero fill[87:83]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]          s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: ok[0], is_initialized[1], complete[2], phase[5:3],
  //        last_reason[8:6], last_from[11:9], last_to[14:12], last_time[46:15],
  //        last_velocity[69:47], last_completed[70], count[73:71], zero[79:74]
  output logic [OutDataW-1:0] m_axis_tdata,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  obs_t       obs_q, obs_d;
  logic       in_vld_q;
  seq_state_t st_q, st_d;
  logic       step_ok;
  seq_state_t res_st_q;
  logic       res_ok_q;
  logic       out_vld_q;
  logic       out_free;
  logic       advance;

  assign cfg_ready_o = 1'b1;

  epsq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Unpack the incoming transfer
  always_comb begin
    obs_d.action          = s_axis_tuser;
    obs_d.time_ms         = s_axis_tdata[31:0];
    obs_d.velocity        = s_axis_tdata[55:32];
    obs_d.dyn_pressure    = s_axis_tdata[79:56];
    obs_d.restart         = s_axis_tdata[80];
    obs_d.intercept_known = s_axis_tdata[81];
    obs_d.intercept_hit   = s_axis_tdata[82];
  end

  // Result register can take a new item when empty or being drained
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      obs_q <= obs_d;
    end
  end

  epsq_step u_step (
    .cfg_i (cfg),
    .obs_i (obs_q),
    .st_i  (st_q),
    .st_o  (st_d),
    .ok_o  (step_ok)
  );

  // Sequencer state: commit only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_st_q <= st_d;
      res_ok_q <= step_ok;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0,
                          res_st_q.count,
                          res_st_q.completed,
                          res_st_q.vel,
                          res_st_q.time_ms,
                          res_st_q.to,
                          res_st_q.from,
                          res_st_q.reason,
                          res_st_q.phase,
                          res_st_q.done,
                          res_st_q.init,
                          res_ok_q};

  // Completion is only reachable from an initialized sequencer in transition
  a_done_in_trans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.done |-> (st_q.init && st_q.phase == PH_TRANS))
    else $error("complete outside transition phase");

  // A rejected item leaves the sequencer state untouched
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !step_ok) |=> (st_q == $past(st_q)))
    else $error("rejected item changed state");

  // The completed record always carries the handoff reason
  a_completed_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.completed |-> (st_q.reason == RS_HAND && st_q.done))
    else $error("completed record without handoff");

  // A result that loads mirrors the state committed on the same edge
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_st_q == st_q))
    else $error("result register out of step with state");

endmodule

### src/epsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// Entry phase sequencer configuration registers
// Decodes register writes by index; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module epsq_cfg_regs import epsq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_TEMP_EN:  cfg_d.temp_gate_enable  = wr_data_i[0];
        CFG_TEMP_VEL: cfg_d.temp_end_velocity = wr_data_i[VelW-1:0];
        CFG_DRAG_EN:  cfg_d.drag_gate_enable  = wr_data_i[0];
        CFG_DRAG_VEL: cfg_d.drag_end_velocity = wr_data_i[VelW-1:0];
        CFG_FLOOR_EN: cfg_d.floor_enable      = wr_data_i[0];
        CFG_FLOOR_PH: cfg_d.floor_phase       = wr_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/epsq_step.sv
// ----------------------------------------------------------------------------
// Entry phase sequencer step logic
// Validates one observation, evaluates the gates and computes the next
// sequencer state and the accept flag.
// ----------------------------------------------------------------------------
module epsq_step import epsq_pkg::*; (
  input  cfg_t       cfg_i,
  input  obs_t       obs_i,
  input  seq_state_t st_i,
  output seq_state_t st_o,
  output logic       ok_o
);

  logic            obs_ok;
  logic            prof_ok;
  logic            dp_pos;
  logic            icpt;
  logic [VelW-1:0] v;
  logic            temp_gate;
  logic            drag_gate;
  logic [2:0]      init_ph;

  assign obs_ok    = !obs_i.velocity[ObsW-1] && !obs_i.dyn_pressure[ObsW-1];
  assign prof_ok   = !(cfg_i.floor_enable && (cfg_i.floor_phase > 3'(PH_TRANS)));
  assign dp_pos    = !obs_i.dyn_pressure[ObsW-1] && (|obs_i.dyn_pressure);
  assign icpt      = obs_i.intercept_known && obs_i.intercept_hit;
  assign v         = obs_ok ? obs_i.velocity[VelW-1:0] : '0;
  assign temp_gate = cfg_i.temp_gate_enable && (v <= cfg_i.temp_end_velocity);
  assign drag_gate = cfg_i.drag_gate_enable && (v <= cfg_i.drag_end_velocity);

  // Restart classification: highest phase whose entry condition holds
  always_comb begin
    init_ph = 3'(PH_PRE);
    if (obs_i.restart) begin
      if (cfg_i.floor_enable) init_ph = cfg_i.floor_phase;
      if (dp_pos && init_ph < 3'(PH_TEMP)) init_ph = 3'(PH_TEMP);
      if (temp_gate && init_ph < 3'(PH_EQ)) init_ph = 3'(PH_EQ);
      if (icpt && init_ph < 3'(PH_DRAG)) init_ph = 3'(PH_DRAG);
      if (drag_gate) init_ph = 3'(PH_TRANS);
    end
  end

  always_comb begin
    seq_state_t init_st;
    seq_state_t rec_st;
    phase_e     to_ph;
    reason_e    rsn;
    logic       move;
    logic       comp;

    init_st           = st_i;
    init_st.init      = 1'b1;
    init_st.done      = 1'b0;
    init_st.phase     = phase_e'(init_ph);
    init_st.reason    = obs_i.restart ? RS_RESTART : RS_START;
    init_st.from      = phase_e'(init_ph);
    init_st.to        = phase_e'(init_ph);
    init_st.time_ms   = obs_i.time_ms;
    init_st.vel       = v;
    init_st.completed = 1'b0;
    init_st.count     = '0;

    // Forward gate of the current phase, or the handoff record
    move  = 1'b0;
    comp  = 1'b0;
    to_ph = st_i.phase;
    rsn   = RS_NONE;
    if (action_e'(obs_i.action) == ACT_HANDOFF) begin
      move  = !st_i.done;
      comp  = 1'b1;
      to_ph = PH_TRANS;
      rsn   = RS_HAND;
    end else begin
      case (st_i.phase)
        PH_PRE:  begin move = dp_pos;    to_ph = PH_TEMP;  rsn = RS_CONTACT; end
        PH_TEMP: begin move = temp_gate; to_ph = PH_EQ;    rsn = RS_TEMP;    end
        PH_EQ:   begin move = icpt;      to_ph = PH_DRAG;  rsn = RS_ICPT;    end
        PH_DRAG: begin move = drag_gate; to_ph = PH_TRANS; rsn = RS_DRAG;    end
        default: ;
      endcase
    end

    rec_st           = st_i;
    rec_st.phase     = to_ph;
    rec_st.done      = st_i.done | comp;
    rec_st.reason    = rsn;
    rec_st.from      = st_i.phase;
    rec_st.to        = to_ph;
    rec_st.time_ms   = obs_i.time_ms;
    rec_st.vel       = v;
    rec_st.completed = comp;
    rec_st.count     = st_i.count + CntW'(1);

    st_o = st_i;
    ok_o = 1'b0;
    case (action_e'(obs_i.action))
      ACT_INIT: begin
        if (obs_ok && prof_ok) begin
          ok_o = 1'b1;
          st_o = init_st;
        end
      end
      ACT_UPDATE: begin
        if (obs_ok && prof_ok) begin
          ok_o = 1'b1;
          if (!st_i.init) begin
            st_o = init_st;
          end else if (!st_i.done && move) begin
            st_o = rec_st;
          end
        end
      end
      ACT_HANDOFF: begin
        if (obs_ok && st_i.init && st_i.phase == PH_TRANS) begin
          ok_o = 1'b1;
          if (move) st_o = rec_st;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/entry_phase_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// Entry phase sequencer core testbench
// Drives observations and register writes into the core, predicts every
// sequencer record in step with the accepted observations, and compares each
// returned record field by field. A directed table walks the corner cases,
// then nine randomized phases sweep configurations and back-pressure patterns.
// ----------------------------------------------------------------------------
module entry_phase_sequencer_core_test;
  import epsq_pkg::*;

  // Stop the run well beyond the slowest legal run (~1400 transfers, heavy stalls)
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  // One predicted record: the ok flag plus the sequencer state after the item
  typedef struct packed {
    logic       ok;
    seq_state_t st;
  } seq_rec_t;

  // One line of the directed table: a register write or an observation
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    obs_t                obs;
    logic                typed;
    seq_rec_t            want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor copy of the configuration and sequencer state
  cfg_t        model_cfg;
  seq_state_t  model_st;
  seq_rec_t    pending_records[$];
  plan_row_t   plan[$];

  int          send_idle;
  int          recv_idle;
  int unsigned mismatch_cnt;
  int unsigned record_idx;
  int unsigned cycles;

  entry_phase_sequencer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Record a move: set the new phase and the whole transition record
  function automatic void log_move(phase_e fr, phase_e to_ph, reason_e rs,
                                   logic [TimeW-1:0] t, logic [VelW-1:0] v,
                                   logic comp);
    model_st.phase     = to_ph;
    model_st.done      = model_st.done | comp;
    model_st.reason    = rs;
    model_st.from      = fr;
    model_st.to        = to_ph;
    model_st.time_ms   = t;
    model_st.vel       = v;
    model_st.completed = comp;
    model_st.count     = model_st.count + 1'b1;
  endfunction

  // Start the sequence; a checkpoint restart takes the highest phase whose
  // entry condition holds, never below the phase floor
  function automatic void start_seq(obs_t o, logic [VelW-1:0] v, logic dp_pos,
                                    logic icpt);
    phase_e ph;
    ph = PH_PRE;
    if (o.restart) begin
      if (model_cfg.floor_enable && model_cfg.floor_phase > ph)
        ph = phase_e'(model_cfg.floor_phase);
      if (dp_pos && ph < PH_TEMP) ph = PH_TEMP;
      if (model_cfg.temp_gate_enable && v <= model_cfg.temp_end_velocity && ph < PH_EQ)
        ph = PH_EQ;
      if (icpt && ph < PH_DRAG) ph = PH_DRAG;
      if (model_cfg.drag_gate_enable && v <= model_cfg.drag_end_velocity)
        ph = PH_TRANS;
    end
    model_st.phase     = ph;
    model_st.init      = 1'b1;
    model_st.done      = 1'b0;
    model_st.reason    = o.restart ? RS_RESTART : RS_START;
    model_st.from      = ph;
    model_st.to        = ph;
    model_st.time_ms   = o.time_ms;
    model_st.vel       = v;
    model_st.completed = 1'b0;
    model_st.count     = '0;
  endfunction

  // Apply one accepted observation to the predictor and return its record
  function automatic seq_rec_t advance_sequencer(obs_t o);
    logic            obs_ok;
    logic            prof_ok;
    logic            dp_pos;
    logic            icpt;
    logic [VelW-1:0] v;
    seq_rec_t        rec;
    obs_ok  = !o.velocity[ObsW-1] && !o.dyn_pressure[ObsW-1];
    prof_ok = !(model_cfg.floor_enable && model_cfg.floor_phase > PH_TRANS);
    dp_pos  = !o.dyn_pressure[ObsW-1] && (o.dyn_pressure != '0);
    icpt    = o.intercept_known && o.intercept_hit;
    v       = o.velocity[VelW-1:0];
    rec.ok  = 1'b0;
    case (o.action)
      ACT_INIT: begin
        if (obs_ok && prof_ok) begin
          start_seq(o, v, dp_pos, icpt);
          rec.ok = 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (obs_ok && prof_ok) begin
          rec.ok = 1'b1;
          if (!model_st.init) begin
            start_seq(o, v, dp_pos, icpt);
          end else if (!model_st.done) begin
            case (model_st.phase)
              PH_PRE: begin
                if (dp_pos) log_move(PH_PRE, PH_TEMP, RS_CONTACT, o.time_ms, v, 1'b0);
              end
              PH_TEMP: begin
                if (model_cfg.temp_gate_enable && v <= model_cfg.temp_end_velocity)
                  log_move(PH_TEMP, PH_EQ, RS_TEMP, o.time_ms, v, 1'b0);
              end
              PH_EQ: begin
                if (icpt) log_move(PH_EQ, PH_DRAG, RS_ICPT, o.time_ms, v, 1'b0);
              end
              PH_DRAG: begin
                if (model_cfg.drag_gate_enable && v <= model_cfg.drag_end_velocity)
                  log_move(PH_DRAG, PH_TRANS, RS_DRAG, o.time_ms, v, 1'b0);
              end
              default: ;
            endcase
          end
        end
      end
      ACT_HANDOFF: begin
        // Handoff ignores the restart floor; it needs valid data, init and PH_TRANS
        if (obs_ok && model_st.init && model_st.phase == PH_TRANS) begin
          rec.ok = 1'b1;
          if (!model_st.done) log_move(PH_TRANS, PH_TRANS, RS_HAND, o.time_ms, v, 1'b1);
        end
      end
      default: ;
    endcase
    rec.st = model_st;
    return rec;
  endfunction

  function automatic seq_rec_t mk_rec(logic ok, logic ini, logic dn, phase_e ph,
                                      reason_e rs, phase_e fr, phase_e to_ph,
                                      logic [TimeW-1:0] t, logic [VelW-1:0] v,
                                      logic comp, logic [CntW-1:0] n);
    seq_rec_t rec;
    rec.ok           = ok;
    rec.st.init      = ini;
    rec.st.done      = dn;
    rec.st.phase     = ph;
    rec.st.reason    = rs;
    rec.st.from      = fr;
    rec.st.to        = to_ph;
    rec.st.time_ms   = t;
    rec.st.vel       = v;
    rec.st.completed = comp;
    rec.st.count     = n;
    return rec;
  endfunction

  function automatic obs_t mk_obs(logic [1:0] act, logic [TimeW-1:0] t,
                                  logic [ObsW-1:0] v, logic [ObsW-1:0] dp,
                                  logic rs, logic kn, logic ht);
    obs_t o;
    o.action          = act;
    o.time_ms         = t;
    o.velocity        = v;
    o.dyn_pressure    = dp;
    o.restart         = rs;
    o.intercept_known = kn;
    o.intercept_hit   = ht;
    return o;
  endfunction

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    plan_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic plan_row_t obs_row(obs_t o);
    plan_row_t row;
    row     = '0;
    row.obs = o;
    return row;
  endfunction

  function automatic plan_row_t typed_row(obs_t o, seq_rec_t want);
    plan_row_t row;
    row       = obs_row(o);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Pick a velocity one step below, at or above a gate threshold
  function automatic logic [ObsW-1:0] near_gate(logic [VelW-1:0] thr);
    int t;
    t = int'(thr) + int'($urandom_range(0, 2)) - 1;
    if (t < 0) t = 0;
    if (t > 8388607) t = 8388607;
    return t[ObsW-1:0];
  endfunction

  // Drop tvalid and hold until every predicted record has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_records.size() != 0);
  endtask

  // Write one register with the core idle, and mirror it in the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    // Drop the write request once it is taken
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TEMP_EN:  model_cfg.temp_gate_enable  = val[0];
      CFG_TEMP_VEL: model_cfg.temp_end_velocity = val[VelW-1:0];
      CFG_DRAG_EN:  model_cfg.drag_gate_enable  = val[0];
      CFG_DRAG_VEL: model_cfg.drag_end_velocity = val[VelW-1:0];
      CFG_FLOOR_EN: model_cfg.floor_enable      = val[0];
      CFG_FLOOR_PH: model_cfg.floor_phase       = val[2:0];
      default: ;
    endcase
  endtask

  // Send one observation, with random idle cycles ahead of it
  task automatic push_obs(input obs_t o, input logic typed, input seq_rec_t want);
    seq_rec_t rec;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, o.intercept_hit, o.intercept_known, o.restart,
                      o.dyn_pressure, o.velocity, o.time_ms};
    s_axis_tuser  <= o.action;
    do @(posedge clk_i); while (!s_axis_tready);
    // Transfer taken at this edge: advance the predictor in acceptance order
    rec = advance_sequencer(o);
    pending_records.push_back(typed ? want : rec);
  endtask

  // Compare every returned record with the oldest prediction; toggle tready
  always @(posedge clk_i) begin : record_check
    seq_rec_t got;
    seq_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok           = m_axis_tdata[0];
      got.st.init      = m_axis_tdata[1];
      got.st.done      = m_axis_tdata[2];
      got.st.phase     = phase_e'(m_axis_tdata[5:3]);
      got.st.reason    = reason_e'(m_axis_tdata[8:6]);
      got.st.from      = phase_e'(m_axis_tdata[11:9]);
      got.st.to        = phase_e'(m_axis_tdata[14:12]);
      got.st.time_ms   = m_axis_tdata[46:15];
      got.st.vel       = m_axis_tdata[69:47];
      got.st.completed = m_axis_tdata[70];
      got.st.count     = m_axis_tdata[73:71];
      if (pending_records.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= REPORT_MAX)
          $display("record %0d: no prediction waiting, got %h", record_idx, got);
      end else begin
        want = pending_records.pop_front();
        if (got.ok !== want.ok || got.st.init !== want.st.init ||
            got.st.done !== want.st.done || got.st.phase !== want.st.phase ||
            got.st.reason !== want.st.reason || got.st.from !== want.st.from ||
            got.st.to !== want.st.to || got.st.time_ms !== want.st.time_ms ||
            got.st.vel !== want.st.vel || got.st.completed !== want.st.completed ||
            got.st.count !== want.st.count) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= REPORT_MAX)
            $display("record %0d mismatch: expected %h got %h", record_idx, want, got);
        end
      end
      record_idx = record_idx + 1;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("entry_phase_sequencer_core_test: errors");
      $finish;
    end
  end

  initial begin
    obs_t            o;
    cfg_t            c;
    seq_rec_t        blank;
    logic [31:0]     rnd;
    logic [ObsW-1:0] vel;
    logic [ObsW-1:0] dp;
    int              pick;
    int              ph;
    int              n;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    model_cfg     = '0;
    model_st      = '0;
    mismatch_cnt  = 0;
    record_idx    = 0;
    cycles        = 0;
    send_idle     = 16;
    recv_idle     = 65;

    // Rejected items before any start leave the all-zero reset record
    blank = mk_rec(1'b0, 1'b0, 1'b0, PH_PRE, RS_NONE, PH_PRE, PH_PRE, '0, '0, 1'b0, '0);

    // Reset configuration: both gates and the floor off
    plan.push_back(typed_row(mk_obs(ACT_HANDOFF, 32'd0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0),
                             blank));
    plan.push_back(typed_row(mk_obs(ACT_UNUSED, 32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                    1'b1, 1'b1, 1'b1), blank));
    plan.push_back(typed_row(mk_obs(ACT_UPDATE, 32'd5, 24'h800000, 24'd0, 1'b0, 1'b0, 1'b0),
                             blank));
    plan.push_back(typed_row(mk_obs(ACT_INIT, 32'd6, 24'd0, 24'hFFFFFF, 1'b1, 1'b0, 1'b0),
                             blank));
    // Update ahead of any initialize starts the sequence
    plan.push_back(typed_row(mk_obs(ACT_UPDATE, 32'hFFFFFFFF, 24'h7FFFFF, 24'd0,
                                    1'b0, 1'b0, 1'b0),
                             mk_rec(1'b1, 1'b1, 1'b0, PH_PRE, RS_START, PH_PRE, PH_PRE,
                                    32'hFFFFFFFF, 23'h7FFFFF, 1'b0, 3'd0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd10, 24'd1000, 24'h7FFFFF,
                                  1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd20, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0)));
    // Open the temperature gate at its widest
    plan.push_back(cfg_row(CFG_TEMP_EN, 23'd1));
    plan.push_back(cfg_row(CFG_TEMP_VEL, 23'h7FFFFF));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd30, 24'h7FFFFF, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd40, 24'd77, 24'd5, 1'b0, 1'b1, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd50, 24'd77, 24'd5, 1'b0, 1'b0, 1'b1)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd60, 24'd77, 24'd5, 1'b0, 1'b1, 1'b1)));
    plan.push_back(obs_row(mk_obs(ACT_HANDOFF, 32'd70, 24'd77, 24'd5, 1'b0, 1'b0, 1'b0)));
    // Drag gate at its narrowest: only a standstill ends constant drag
    plan.push_back(cfg_row(CFG_DRAG_EN, 23'd1));
    plan.push_back(cfg_row(CFG_DRAG_VEL, 23'd0));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd80, 24'd1, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd90, 24'd0, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd100, 24'd0, 24'd5, 1'b0, 1'b1, 1'b1)));
    plan.push_back(obs_row(mk_obs(ACT_HANDOFF, 32'd110, 24'h123, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_HANDOFF, 32'd120, 24'h456, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd130, 24'd0, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_HANDOFF, 32'd140, 24'd0, 24'h800000,
                                  1'b0, 1'b0, 1'b0)));
    // Floor above the transition phase: invalid profile
    plan.push_back(cfg_row(CFG_FLOOR_EN, 23'd1));
    plan.push_back(cfg_row(CFG_FLOOR_PH, 23'd7));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd150, 24'd9, 24'd5, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_INIT, 32'd160, 24'd9, 24'd5, 1'b1, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_HANDOFF, 32'd170, 24'd9, 24'd5, 1'b0, 1'b0, 1'b0)));
    // Restart classification against a legal floor
    plan.push_back(cfg_row(CFG_FLOOR_PH, 23'd2));
    plan.push_back(obs_row(mk_obs(ACT_INIT, 32'd180, 24'd100, 24'd0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_INIT, 32'd190, 24'd0, 24'd0, 1'b1, 1'b1, 1'b1)));
    plan.push_back(cfg_row(CFG_FLOOR_EN, 23'd0));
    plan.push_back(cfg_row(CFG_TEMP_EN, 23'd0));
    plan.push_back(cfg_row(CFG_DRAG_EN, 23'd0));
    plan.push_back(obs_row(mk_obs(ACT_INIT, 32'd200, 24'd5, 24'd0, 1'b1, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_INIT, 32'd0, 24'd0, 24'd1, 1'b0, 1'b0, 1'b0)));
    plan.push_back(obs_row(mk_obs(ACT_UPDATE, 32'd210, 24'd0, 24'd1, 1'b0, 1'b0, 1'b0)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else push_obs(plan[i].obs, plan[i].typed, plan[i].want);
    end

    // Randomized phases: sender-light/receiver-heavy idling, then swapped,
    // then full rate
    for (ph = 0; ph < 9; ph++) begin
      send_idle = (ph < 3) ? 16 : (ph < 6) ? 65 : 0;
      recv_idle = (ph < 3) ? 65 : (ph < 6) ? 16 : 0;
      if (ph == 0) begin
        c.temp_gate_enable  = 1'b1;
        c.temp_end_velocity = 23'h7FFFFF;
        c.drag_gate_enable  = 1'b1;
        c.drag_end_velocity = 23'h7FFFFF;
        c.floor_enable      = 1'b1;
        c.floor_phase       = 3'd4;
      end else if (ph == 1) begin
        c = '0;
      end else begin
        c.temp_gate_enable  = ($urandom_range(0, 3) != 0);
        rnd                 = $urandom;
        c.temp_end_velocity = rnd[VelW-1:0];
        c.drag_gate_enable  = ($urandom_range(0, 3) != 0);
        rnd                 = $urandom;
        c.drag_end_velocity = rnd[VelW-1:0];
        c.floor_enable      = 1'($urandom_range(0, 1));
        c.floor_phase       = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
      end
      // Fill unused data bits with noise; the core keeps only the register width
      rnd = $urandom;
      write_reg(CFG_TEMP_EN,  {rnd[22:1], c.temp_gate_enable});
      write_reg(CFG_TEMP_VEL, c.temp_end_velocity);
      write_reg(CFG_DRAG_EN,  {rnd[31:10], c.drag_gate_enable});
      write_reg(CFG_DRAG_VEL, c.drag_end_velocity);
      write_reg(CFG_FLOOR_EN, {rnd[27:6], c.floor_enable});
      write_reg(CFG_FLOOR_PH, {rnd[19:0], c.floor_phase});

      for (n = 0; n < 150; n++) begin
        // Hold the sender mid-phase until the pipeline is empty
        if (n == 75) drain();
        pick = $urandom_range(0, 99);
        if (pick < 12)      o.action = ACT_INIT;
        else if (pick < 82) o.action = ACT_UPDATE;
        else if (pick < 95) o.action = ACT_HANDOFF;
        else                o.action = ACT_UNUSED;
        o.time_ms = $urandom;
        rnd = $urandom;
        case ($urandom_range(0, 9))
          0:       vel = rnd[ObsW-1:0];
          1:       vel = '0;
          2:       vel = 24'h7FFFFF;
          3:       vel = near_gate(model_cfg.temp_end_velocity);
          4:       vel = near_gate(model_cfg.drag_end_velocity);
          default: vel = {1'b0, rnd[VelW-1:0]};
        endcase
        rnd = $urandom;
        case ($urandom_range(0, 9))
          0:       dp = rnd[ObsW-1:0];
          1, 2:    dp = '0;
          default: dp = {1'b0, rnd[VelW-1:0]};
        endcase
        o.velocity        = vel;
        o.dyn_pressure    = dp;
        o.restart         = 1'($urandom_range(0, 1));
        o.intercept_known = 1'($urandom_range(0, 1));
        o.intercept_hit   = 1'($urandom_range(0, 1));
        push_obs(o, 1'b0, '0);
      end
    end

    // Let the last records drain, then allow the pipeline to settle
    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_records.size() == 0) begin
      $display("entry_phase_sequencer_core_test: clean");
    end else begin
      $display("entry_phase_sequencer_core_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/epsq_pkg.sv
src/epsq_cfg_regs.sv
src/epsq_step.sv
src/entry_phase_sequencer_core.sv
tb/sv/entry_phase_sequencer_core_test.sv
